### hw/rtl/dnsc_pkg.sv
// shared types, constants and helpers for the dns name caseless compare block
// no dependencies
`default_nettype none

package dnsc_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned APB_ADDR_W = 2;

	localparam logic [APB_ADDR_W-1:0] REG_MAX_LABEL_ADDR = '0;
	localparam logic [BYTE_W-1:0]     MAX_LABEL_RESET    = 8'd63;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_LEN   = 2'd1;
	localparam logic [1:0] PH_LABEL = 2'd2;

	localparam logic [BYTE_W-1:0] ASCII_UPPER_A = 8'h41;
	localparam logic [BYTE_W-1:0] ASCII_UPPER_Z = 8'h5a;
	localparam logic [BYTE_W-1:0] ASCII_CASE    = 8'h20;

	typedef struct packed {
		logic              start_flag;
		logic [BYTE_W-1:0] byte_one;
		logic [BYTE_W-1:0] byte_two;
	} item_t;

	typedef struct packed {
		logic hit;
		logic equal;
	} verdict_t;

	function automatic logic [BYTE_W-1:0] ascii_lower(input logic [BYTE_W-1:0] c);
		logic [BYTE_W-1:0] r;
		r = c;
		if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
			r = c + ASCII_CASE;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/dnsc_if.sv
// valid/ready channel interfaces for the byte pair input and the verdict output
// depends on dnsc_pkg
`default_nettype none

interface dnsc_item_if;
	logic                       valid;
	logic                       ready;
	logic                       start_flag;
	logic [dnsc_pkg::BYTE_W-1:0] byte_one;
	logic [dnsc_pkg::BYTE_W-1:0] byte_two;

	modport source(output valid, output start_flag, output byte_one, output byte_two,
		input ready);
	modport sink(input valid, input start_flag, input byte_one, input byte_two,
		output ready);
endinterface

interface dnsc_result_if;
	logic valid;
	logic ready;
	logic names_equal;

	modport source(output valid, output names_equal, input ready);
	modport sink(input valid, input names_equal, output ready);
endinterface

`default_nettype wire

### hw/rtl/dnsc_apb_regs.sv
// apb configuration register holding the label length limit
// depends on dnsc_pkg
`default_nettype none

module dnsc_apb_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [dnsc_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [dnsc_pkg::APB_DATA_W-1:0]    pwdata,
	output logic      [dnsc_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                    pready,
	output logic      [dnsc_pkg::BYTE_W-1:0]        max_label
);

	logic [dnsc_pkg::BYTE_W-1:0] max_label_q;
	logic                        sel_max;

	assign sel_max   = (paddr == dnsc_pkg::REG_MAX_LABEL_ADDR);
	assign pready    = 1'b1;
	assign max_label = max_label_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_label_q <= dnsc_pkg::MAX_LABEL_RESET;
		end else if (psel && penable && pwrite && pready && sel_max) begin
			max_label_q <= pwdata[dnsc_pkg::BYTE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_max) begin
			prdata[dnsc_pkg::BYTE_W-1:0] = max_label_q;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/dnsc_label_fsm.sv
// phase and label counter tracking for one comparison, with the verdict decision
// depends on dnsc_pkg
`default_nettype none

module dnsc_label_fsm (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        advance,
	input  wire dnsc_pkg::item_t             item,
	input  wire logic [dnsc_pkg::BYTE_W-1:0] max_label,
	output dnsc_pkg::verdict_t               verdict,
	output logic [1:0]                       phase,
	output logic [dnsc_pkg::BYTE_W-1:0]      label_left
);

	logic [1:0]                  phase_q, phase_d, phase_eff;
	logic [dnsc_pkg::BYTE_W-1:0] left_q, left_d, left_dec;

	assign phase      = phase_q;
	assign label_left = left_q;
	assign left_dec   = left_q - 8'd1;

	always_comb begin
		phase_eff = item.start_flag ? dnsc_pkg::PH_LEN : phase_q;
		phase_d   = phase_q;
		left_d    = left_q;
		verdict   = '0;
		if (item.start_flag) begin
			left_d = '0;
		end
		case (phase_eff)
			dnsc_pkg::PH_LEN: begin
				if (item.byte_one != item.byte_two || item.byte_one > max_label) begin
					phase_d = dnsc_pkg::PH_IDLE;
					verdict = '{hit: 1'b1, equal: 1'b0};
				end else if (item.byte_one == '0) begin
					phase_d = dnsc_pkg::PH_IDLE;
					verdict = '{hit: 1'b1, equal: 1'b1};
				end else begin
					phase_d = dnsc_pkg::PH_LABEL;
					left_d  = item.byte_one;
				end
			end
			dnsc_pkg::PH_LABEL: begin
				if (dnsc_pkg::ascii_lower(item.byte_one)
						!= dnsc_pkg::ascii_lower(item.byte_two)) begin
					phase_d = dnsc_pkg::PH_IDLE;
					left_d  = '0;
					verdict = '{hit: 1'b1, equal: 1'b0};
				end else begin
					left_d = left_dec;
					if (left_dec == '0) begin
						phase_d = dnsc_pkg::PH_LEN;
					end
				end
			end
			default: begin
				phase_d = dnsc_pkg::PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dnsc_pkg::PH_IDLE;
			left_q  <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			left_q  <= left_d;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/dns_name_caseless_compare_core.sv
// top level of the dns name caseless compare block
// depends on dnsc_pkg, dnsc_if, dnsc_apb_regs and dnsc_label_fsm
`default_nettype none

// Compares two wire-format DNS names byte pair by byte pair, ignoring ASCII case.
// A transaction with start_flag set opens a comparison; a verdict transaction
// (names_equal) appears once the names are found to differ, a label length exceeds
// max_label_length (APB register at address 0, reset 63), or both names end with
// a zero length byte. Each byte pair goes through an input register and one
// decision step into the output register, so the block takes one transaction per
// cycle unless a held verdict stalls it. A held verdict stalls the input only when
// the next pair also produces a verdict.
module dns_name_caseless_compare_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	dnsc_item_if.sink                            item_in,
	dnsc_result_if.source                        result_out,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [dnsc_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [dnsc_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [dnsc_pkg::APB_DATA_W-1:0] prdata,
	output logic                                 pready
);

	logic                        valid_s1;
	dnsc_pkg::item_t             item_s1;
	logic                        out_valid_q;
	logic                        out_equal_q;
	logic                        advance;
	logic                        in_fire;
	logic [dnsc_pkg::BYTE_W-1:0] max_label;
	logic [1:0]                  phase;
	logic [dnsc_pkg::BYTE_W-1:0] label_left;
	dnsc_pkg::verdict_t          verdict;

	dnsc_apb_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.max_label (max_label)
	);

	dnsc_label_fsm u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.item       (item_s1),
		.max_label  (max_label),
		.verdict    (verdict),
		.phase      (phase),
		.label_left (label_left)
	);

	assign advance = valid_s1 && (!verdict.hit || !out_valid_q || result_out.ready);
	assign item_in.ready = !valid_s1 || advance;
	assign in_fire = item_in.valid && item_in.ready;

	assign result_out.valid       = out_valid_q;
	assign result_out.names_equal = out_equal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_in.ready) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= '{start_flag: item_in.start_flag, byte_one: item_in.byte_one,
				byte_two: item_in.byte_two};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && verdict.hit) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && verdict.hit) begin
			out_equal_q <= verdict.equal;
		end
	end

	// a new verdict only comes from a pair leaving the input register
	a_verdict_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance && verdict.hit))
		else $error("verdict raised without a decided pair");

	// a held verdict is never overwritten by another one
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result_out.ready && valid_s1 && verdict.hit) |-> !advance)
		else $error("pending verdict overwritten");

	// in the label phase at least one label byte pair is still due
	a_label_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase == dnsc_pkg::PH_LABEL) |-> (label_left != '0))
		else $error("label phase with no bytes left");

	// the unused phase code is never reached
	a_phase_code: assert property (@(posedge clk) disable iff (!arst_n)
		phase != 2'd3)
		else $error("phase register holds unused code");

endmodule

`default_nettype wire
